// ----- rtl/ofmt_pkg.sv -----
`default_nettype none

package ofmt_pkg;

    // Largest number of characters one word may produce.
    localparam int MAX_FIELD_DEF = 63;

    // Octal digit register: 22 digits cover a 64-bit argument.
    localparam int NDIG_MAX = 22;
    localparam int DIG_W    = 3 * NDIG_MAX;
    localparam int REM_W    = 5;

    // Digit counts for each argument size.
    localparam logic [REM_W-1:0] NDIG_8  = REM_W'(3);
    localparam logic [REM_W-1:0] NDIG_16 = REM_W'(6);
    localparam logic [REM_W-1:0] NDIG_32 = REM_W'(11);
    localparam logic [REM_W-1:0] NDIG_64 = REM_W'(22);

    // Argument size codes.
    localparam logic [1:0] SIZE_32 = 2'd0;
    localparam logic [1:0] SIZE_8  = 2'd1;
    localparam logic [1:0] SIZE_16 = 2'd2;
    localparam logic [1:0] SIZE_64 = 2'd3;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  size_sel;
        logic        alternate;
        logic        zero_pad;
        logic        left_adjust;
        logic        has_precision;
        logic [5:0]  precision;
        logic [5:0]  field_width;
    } ofmt_in_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       ch_valid;
        logic       last;
    } ofmt_out_t;

endpackage

`default_nettype wire

// ----- rtl/octal_field_formatter.sv -----
`default_nettype none

// Octal field formatter.
//
// A command word is presented on args with start high; it is taken at the
// rising edge where start is high and busy is low. busy then stays high
// until the last character of the word has been produced.
// Results leave one character per cycle on result, each marked by a
// one-cycle result_valid strobe; result.last flags the final one. A word
// whose formatted text is empty gives a single result with ch_valid low.
// The receiver cannot stall: every strobe is a delivered word.
//
// Timing: after acceptance the digit register is scanned one octal digit
// per cycle to strip leading zero digits (up to 22 of them for a zero
// 64-bit argument); once the scan ends, the padding is sized in a state of
// its own. Then one character is issued per cycle, n characters with n at
// most MAX_FIELD. busy stays high through the scan, the sizing and the
// characters, and each strobe trails its issue cycle by one register.
// The digit scan and the one-character-per-cycle output set the rate;
// a new word may be accepted on the edge that carries the last strobe.
//
// Reset clears the sequencer and the strobe; no word is in flight after it.

module octal_field_formatter
    import ofmt_pkg::*;
#(
    parameter int MAX_FIELD = MAX_FIELD_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire ofmt_in_t  args,
    output logic           busy,
    output logic           result_valid,
    output ofmt_out_t      result
);

    localparam int LEFT_W = $clog2(MAX_FIELD + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CALC,
        ST_EMIT
    } state_t;

    state_t             state_reg,    state_next;
    logic [DIG_W-1:0]   dig_reg,      dig_next;
    logic [REM_W-1:0]   rem_reg,      rem_next;
    logic               alt_reg,      alt_next;
    logic               zp_reg,       zp_next;
    logic               la_reg,       la_next;
    logic               hp_reg,       hp_next;
    logic [5:0]         prec_reg,     prec_next;
    logic [5:0]         fw_reg,       fw_next;
    logic [5:0]         lead_reg,     lead_next;
    logic [5:0]         zero_reg,     zero_next;
    logic [LEFT_W-1:0]  left_reg,     left_next;
    logic               rv_reg,       rv_next;
    ofmt_out_t          res_reg,      res_next;

    // Padding arithmetic for the sizing cycle.
    logic               empty_digits;
    logic [REM_W-1:0]   nd;
    logic [5:0]         base_len;
    logic [5:0]         prec_len;
    logic [5:0]         text_len;
    logic [5:0]         spaces;
    logic [5:0]         total;
    logic               has_text;
    logic [2:0]         top_digit;

    assign top_digit = dig_reg[DIG_W-1 -: 3];

    always_comb
    begin
        // A zero argument keeps one '0' digit unless an explicit zero
        // precision or the alternate form removes it.
        empty_digits = (rem_reg == '0) && ((hp_reg && (prec_reg == '0)) || alt_reg);
        nd = ((rem_reg == '0) && !empty_digits) ? REM_W'(1) : rem_reg;
        has_text = (nd != '0) || alt_reg;
        base_len = 6'(nd) + 6'(alt_reg);
        prec_len = (hp_reg && (prec_reg > base_len)) ? prec_reg : base_len;
        if (!has_text)
        begin
            text_len = '0;
        end
        else if (zp_reg && (fw_reg > prec_len))
        begin
            // Zero fill makes up the whole field, precision zeros included.
            text_len = fw_reg;
        end
        else
        begin
            text_len = prec_len;
        end
        spaces = (fw_reg > text_len) ? (fw_reg - text_len) : '0;
        total  = text_len + spaces;
    end

    always_comb
    begin
        state_next = state_reg;
        dig_next   = dig_reg;
        rem_next   = rem_reg;
        alt_next   = alt_reg;
        zp_next    = zp_reg;
        la_next    = la_reg;
        hp_next    = hp_reg;
        prec_next  = prec_reg;
        fw_next    = fw_reg;
        lead_next  = lead_reg;
        zero_next  = zero_reg;
        left_next  = left_reg;
        rv_next    = 1'b0;
        res_next   = res_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    alt_next  = args.alternate;
                    zp_next   = args.zero_pad;
                    la_next   = args.left_adjust;
                    hp_next   = args.has_precision;
                    prec_next = args.precision;
                    fw_next   = args.field_width;
                    // Left-align the truncated argument on a digit boundary.
                    unique case (args.size_sel)
                        SIZE_8:
                        begin
                            dig_next = {1'b0, args.value[7:0], (DIG_W - 9)'(0)};
                            rem_next = NDIG_8;
                        end
                        SIZE_16:
                        begin
                            dig_next = {2'b0, args.value[15:0], (DIG_W - 18)'(0)};
                            rem_next = NDIG_16;
                        end
                        SIZE_32:
                        begin
                            dig_next = {1'b0, args.value[31:0], (DIG_W - 33)'(0)};
                            rem_next = NDIG_32;
                        end
                        SIZE_64:
                        begin
                            dig_next = {2'b0, args.value};
                            rem_next = NDIG_64;
                        end
                    endcase
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // Strip one leading zero digit per cycle.
                if ((rem_reg != '0) && (top_digit == 3'd0))
                begin
                    dig_next = {dig_reg[DIG_W-4:0], 3'b000};
                    rem_next = rem_reg - REM_W'(1);
                end
                else
                begin
                    state_next = ST_CALC;
                end
            end

            ST_CALC:
            begin
                rem_next  = nd;
                zero_next = text_len - base_len;
                lead_next = la_reg ? 6'd0 : spaces;
                if (total == '0)
                begin
                    res_next.ch       = '0;
                    res_next.ch_valid = 1'b0;
                    res_next.last     = 1'b1;
                    rv_next           = 1'b1;
                    state_next        = ST_IDLE;
                end
                else
                begin
                    left_next  = (total > 6'(MAX_FIELD)) ? LEFT_W'(MAX_FIELD)
                                                         : LEFT_W'(total);
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                res_next.ch_valid = 1'b1;
                res_next.last     = (left_reg == LEFT_W'(1));
                rv_next           = 1'b1;
                priority if (lead_reg != '0)
                begin
                    res_next.ch = CHAR_SPACE;
                    lead_next   = lead_reg - 6'd1;
                end
                else if (alt_reg)
                begin
                    res_next.ch = CHAR_ZERO;
                    alt_next    = 1'b0;
                end
                else if (zero_reg != '0)
                begin
                    res_next.ch = CHAR_ZERO;
                    zero_next   = zero_reg - 6'd1;
                end
                else if (rem_reg != '0)
                begin
                    res_next.ch = CHAR_ZERO | {5'b00000, top_digit};
                    dig_next    = {dig_reg[DIG_W-4:0], 3'b000};
                    rem_next    = rem_reg - REM_W'(1);
                end
                else
                begin
                    // Trailing spaces under left adjust.
                    res_next.ch = CHAR_SPACE;
                end
                left_next = left_reg - LEFT_W'(1);
                if (left_reg == LEFT_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rv_reg    <= 1'b0;
            dig_reg   <= '0;
            rem_reg   <= '0;
            alt_reg   <= 1'b0;
            zp_reg    <= 1'b0;
            la_reg    <= 1'b0;
            hp_reg    <= 1'b0;
            prec_reg  <= '0;
            fw_reg    <= '0;
            lead_reg  <= '0;
            zero_reg  <= '0;
            left_reg  <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
            dig_reg   <= dig_next;
            rem_reg   <= rem_next;
            alt_reg   <= alt_next;
            zp_reg    <= zp_next;
            la_reg    <= la_next;
            hp_reg    <= hp_next;
            prec_reg  <= prec_next;
            fw_reg    <= fw_next;
            lead_reg  <= lead_next;
            zero_reg  <= zero_next;
            left_reg  <= left_next;
            res_reg   <= res_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = rv_reg;
    assign result       = res_reg;

    // A strobe only follows a cycle in which a word was being worked on.
    a_strobe_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result strobe without a word in progress");

    // The last character of a word is never followed directly by another.
    a_last_ends_word: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |=> !result_valid)
        else $error("result strobe right after the last character");

    // An empty text is always a single, final result.
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.ch_valid) |-> result.last)
        else $error("empty result not marked last");

    // The digit count never exceeds the widest argument.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (rem_reg <= NDIG_64))
        else $error("digit count out of range");

    // The character count never exceeds the field limit.
    a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> ((left_reg != '0) && (32'(left_reg) <= MAX_FIELD)))
        else $error("character count out of range");

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ofmt_pkg::*;

    // Cycles without any accepted word or delivered result before the run is
    // declared hung. The slowest correct word, with its idle gap before it,
    // its digit scan and 63 characters, still stays far below this.
    localparam int unsigned QUIET_LIMIT = 4000;
    // Cycles to wait after the last expected character has arrived, so that
    // a stray extra result still gets caught.
    localparam int unsigned DRAIN_CYCLES = 100;
    localparam int unsigned RANDOM_WORDS = 150;

    // Expected octal text for each accepted word, one character per entry.
    // The formatting rules are computed here from the command fields alone.
    class octal_text_scoreboard;
        ofmt_out_t   expected_chars[$];
        int unsigned mismatches;
        int unsigned words_noted;
        int unsigned chars_checked;
        int unsigned empty_texts;

        function new();
            mismatches    = 0;
            words_noted   = 0;
            chars_checked = 0;
            empty_texts   = 0;
        endfunction

        // Formats one accepted word and queues the characters it must give.
        function void note_word(ofmt_in_t w);
            logic [63:0] v;
            logic [7:0]  digits[$];
            logic [7:0]  text[$];
            int unsigned nd;
            int unsigned alt;
            int unsigned zeros;
            int unsigned len;
            int unsigned spaces;
            int unsigned n;
            ofmt_out_t   r;

            v = w.value;
            case (w.size_sel)
                SIZE_8:  v = v & 64'hFF;
                SIZE_16: v = v & 64'hFFFF;
                SIZE_32: v = v & 64'hFFFF_FFFF;
                default: v = v;
            endcase

            // A zero argument has no digits when the precision is an explicit
            // zero or when the alternate form will supply the zero itself.
            while (v != 64'd0) begin
                digits.push_front(CHAR_ZERO + {5'd0, v[2:0]});
                v = v >> 3;
            end
            if (digits.size() == 0 && !((w.has_precision && w.precision == 6'd0)
                                        || w.alternate))
                digits.push_back(CHAR_ZERO);

            nd    = digits.size();
            alt   = w.alternate ? 1 : 0;
            zeros = 0;
            if (nd != 0 || alt != 0) begin
                len = nd + alt;
                if (w.has_precision && w.precision > len)
                    zeros = w.precision - len;
                len += zeros;
                // Zero padding tops up whatever the precision already added.
                if (w.zero_pad && w.field_width > len)
                    zeros += w.field_width - len;
            end
            len    = alt + zeros + nd;
            spaces = (w.field_width > len) ? w.field_width - len : 0;

            if (!w.left_adjust)
                repeat (spaces) text.push_back(CHAR_SPACE);
            if (alt != 0)
                text.push_back(CHAR_ZERO);
            repeat (zeros) text.push_back(CHAR_ZERO);
            foreach (digits[i])
                text.push_back(digits[i]);
            if (w.left_adjust)
                repeat (spaces) text.push_back(CHAR_SPACE);

            words_noted++;
            if (text.size() == 0) begin
                r.ch       = 8'h00;
                r.ch_valid = 1'b0;
                r.last     = 1'b1;
                expected_chars.push_back(r);
                empty_texts++;
                return;
            end
            n = (text.size() > MAX_FIELD_DEF) ? MAX_FIELD_DEF : text.size();
            for (int unsigned i = 0; i < n; i++) begin
                r.ch       = text[i];
                r.ch_valid = 1'b1;
                r.last     = (i + 1 == n);
                expected_chars.push_back(r);
            end
        endfunction

        // Compares one delivered result with the oldest expected character.
        function void check_result(ofmt_out_t got);
            ofmt_out_t want;

            if (expected_chars.size() == 0) begin
                $error("result with nothing expected: ch=%02h ch_valid=%b last=%b",
                       got.ch, got.ch_valid, got.last);
                mismatches++;
                return;
            end
            want = expected_chars.pop_front();
            chars_checked++;
            if (got.ch !== want.ch) begin
                $error("ch: expected %02h, got %02h", want.ch, got.ch);
                mismatches++;
            end
            if (got.ch_valid !== want.ch_valid) begin
                $error("ch_valid: expected %b, got %b", want.ch_valid, got.ch_valid);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %b, got %b", want.last, got.last);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    ofmt_in_t    args = '0;
    logic        busy;
    logic        result_valid;
    ofmt_out_t   result;

    octal_text_scoreboard sb = new();

    int unsigned quiet_cycles = 0;
    int unsigned directed_words = 0;
    int unsigned random_words = 0;

    octal_field_formatter DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .args         (args),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    always #5 clk = ~clk;

    // Every strobe is a delivered result: the receiver cannot push back, so
    // the monitor simply checks each one at the edge that ends its cycle.
    always @(posedge clk) begin
        if (rst_n && result_valid)
            sb.check_result(result);
    end

    // The watchdog restarts whenever a word is taken or a result shows up.
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || result_valid) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no word taken and no result for %0d cycles",
                     QUIET_LIMIT);
            $display("** octal_field_formatter: FAILED **");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic ofmt_in_t make_word(logic [63:0] value, logic [1:0] size_sel,
                                           bit alt, bit zp, bit la, bit hp,
                                           int unsigned prec, int unsigned fw);
        ofmt_in_t w;

        w.value         = value;
        w.size_sel      = size_sel;
        w.alternate     = alt;
        w.zero_pad      = zp;
        w.left_adjust   = la;
        w.has_precision = hp;
        w.precision     = 6'(prec);
        w.field_width   = 6'(fw);
        return w;
    endfunction

    // Random command word. Values are mixed so that every digit count shows
    // up, and widths and precisions mostly stay short to keep words quick.
    function automatic ofmt_in_t random_word();
        ofmt_in_t    w;
        int unsigned pick;

        pick = $urandom_range(0, 9);
        case (pick)
            0:       w.value = 64'd0;
            1:       w.value = 64'($urandom_range(1, 63));
            2:       w.value = '1;
            3:       w.value = 64'd1 << $urandom_range(0, 63);
            default: w.value = {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
        w.size_sel      = 2'($urandom_range(0, 3));
        w.alternate     = 1'($urandom_range(0, 1));
        w.zero_pad      = 1'($urandom_range(0, 1));
        w.left_adjust   = 1'($urandom_range(0, 1));
        w.has_precision = 1'($urandom_range(0, 1));
        w.precision     = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                      : 6'($urandom_range(0, 24));
        w.field_width   = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                      : 6'($urandom_range(0, 24));
        return w;
    endfunction

    // Presents one word after an optional idle gap and returns at the edge
    // where it is taken. With no gap, start stays high from the previous word
    // so it is never lowered and raised within one time step.
    task automatic send_word(input ofmt_in_t w, input int unsigned gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        args  <= w;
        do @(posedge clk); while (busy);
        sb.note_word(w);
    endtask

    // Gaps come in runs: some stretches send back to back, others idle for a
    // random gap before every word, so pauses land on every phase
    // of the digit scan and the character stream.
    function automatic int unsigned draw_gap(bit back_to_back);
        if (back_to_back)
            return 0;
        return $urandom_range(0, 15);
    endfunction

    initial begin
        ofmt_in_t    directed[$];
        bit          back_to_back;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero argument in its several guises: the plain zero digit, the
        // empty text from an explicit zero precision, space padding around
        // an empty digit string, and the alternate zero standing alone.
        directed.push_back(make_word(64'd0, SIZE_32, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_word(64'd0, SIZE_32, 0, 0, 0, 1, 0, 0));
        directed.push_back(make_word(64'd0, SIZE_64, 0, 0, 0, 1, 0, 5));
        directed.push_back(make_word(64'd0, SIZE_8, 0, 1, 0, 1, 0, 6));
        directed.push_back(make_word(64'd0, SIZE_16, 1, 0, 0, 0, 0, 0));
        directed.push_back(make_word(64'd0, SIZE_16, 1, 0, 1, 1, 0, 4));
        directed.push_back(make_word(64'd0, SIZE_32, 1, 1, 0, 1, 3, 8));
        // Truncation to every argument size, including upper bits that must
        // vanish entirely under the narrow sizes.
        directed.push_back(make_word('1, SIZE_8, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_word('1, SIZE_16, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_word('1, SIZE_32, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_word('1, SIZE_64, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_word(64'hDEAD_BEEF_0000_0000, SIZE_32, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_word(64'h8000_0000_0000_0000, SIZE_64, 1, 0, 0, 0, 0, 0));
        // Precision below and above the digit count, with the alternate zero
        // counted as one of the digits.
        directed.push_back(make_word(64'o777, SIZE_16, 0, 0, 0, 1, 2, 0));
        directed.push_back(make_word(64'o10, SIZE_8, 1, 0, 0, 1, 4, 0));
        directed.push_back(make_word(64'o1234, SIZE_32, 0, 0, 0, 1, 63, 0));
        // Zero padding alone and together with a precision, where the fill
        // has to reach the field width on top of the precision zeros.
        directed.push_back(make_word(64'o17, SIZE_32, 0, 1, 0, 0, 0, 9));
        directed.push_back(make_word(64'd8, SIZE_32, 0, 1, 0, 1, 5, 10));
        directed.push_back(make_word(64'd8, SIZE_32, 1, 1, 1, 1, 5, 12));
        // Space padding on either side, up to the widest field.
        directed.push_back(make_word(64'o5, SIZE_8, 0, 0, 0, 0, 0, 63));
        directed.push_back(make_word(64'o5, SIZE_8, 1, 0, 1, 0, 0, 63));
        directed.push_back(make_word('1, SIZE_64, 0, 0, 1, 1, 30, 40));
        // Longest possible text, with every flag set and then without left adjust.
        directed.push_back(make_word('1, SIZE_64, 1, 1, 1, 1, 63, 63));
        directed.push_back(make_word('1, SIZE_64, 1, 1, 0, 1, 10, 63));

        back_to_back = 1'b0;
        foreach (directed[i]) begin
            if (i % 8 == 0)
                back_to_back = ~back_to_back;
            send_word(directed[i], draw_gap(back_to_back));
            directed_words++;
        end

        for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
            if ($urandom_range(0, 19) == 0)
                back_to_back = ~back_to_back;
            send_word(random_word(), draw_gap(back_to_back));
            random_words++;
        end

        start <= 1'b0;
        while (sb.expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d command words (%0d directed, %0d random).",
                 directed_words + random_words, directed_words, random_words);
        $display("Checked %0d characters, %0d of them empty-text results; %0d mismatches.",
                 sb.chars_checked, sb.empty_texts, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_chars.size() == 0)
            $display("** octal_field_formatter: PASSED **");
        else
            $display("** octal_field_formatter: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
